// ===== rtl/hsc_pkg.sv =====
`timescale 1ns / 1ps

package hsc_pkg;

   localparam int WORD_BITS         = 64;
   localparam int COUNT_W           = 7;
   localparam int SYN_W             = 7;
   localparam int LEN_W             = 8;
   localparam int CODE_BITS_DEFAULT = 64;

   localparam logic KIND_ENCODE = 1'b0;
   localparam logic KIND_DECODE = 1'b1;

   typedef struct packed {
      logic                 kind;
      logic [COUNT_W-1:0]   bit_count;
      logic [WORD_BITS-1:0] bits_in;
   } hsc_item_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] bits_out;
      logic [COUNT_W-1:0]   out_count;
      logic [SYN_W-1:0]     syndrome;
      logic                 range_error;
   } hsc_result_type;

   // Position p is a parity slot when p is a power of two.
   function automatic logic is_pow2(input int p);
      return (p != 0) && ((p & (p - 1)) == 0);
   endfunction

   // Number of powers of two not above p.
   function automatic int pow2_upto(input int p);
      int n;
      n = 0;
      for (int k = 0; k < SYN_W; k++) begin
         if ((1 << k) <= p) n++;
      end
      return n;
   endfunction

   // Data index carried at a non-parity position p.
   function automatic int data_index(input int p);
      return p - 1 - pow2_upto(p);
   endfunction

   // Vector bits whose position number has bit k set.
   function automatic logic [WORD_BITS-1:0] parity_mask(input int k);
      logic [WORD_BITS-1:0] m;
      m = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         m[i] = 1'(((i + 1) >> k) & 1);
      end
      return m;
   endfunction

endpackage

// ===== rtl/hsc_channels.sv =====
`timescale 1ns / 1ps

interface hsc_req_if import hsc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 kind;
   logic [COUNT_W-1:0]   bit_count;
   logic [WORD_BITS-1:0] bits_in;

   modport source (output valid, kind, bit_count, bits_in, input ready);
   modport sink   (input valid, kind, bit_count, bits_in, output ready);
endinterface

interface hsc_rsp_if import hsc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [WORD_BITS-1:0] bits_out;
   logic [COUNT_W-1:0]   out_count;
   logic [SYN_W-1:0]     syndrome;
   logic                 range_error;

   modport source (output valid, bits_out, out_count, syndrome, range_error, input ready);
   modport sink   (input valid, bits_out, out_count, syndrome, range_error, output ready);
endinterface

// ===== rtl/hsc_encoder.sv =====
`timescale 1ns / 1ps

module hsc_encoder import hsc_pkg::*; #(
   parameter int CODE_BITS = CODE_BITS_DEFAULT
) (
   input  logic [COUNT_W-1:0]   bit_count,
   input  logic [WORD_BITS-1:0] bits_in,
   output hsc_result_type       result
);

   logic [WORD_BITS-1:0] data_m;
   logic [WORD_BITS-1:0] scattered;
   logic [WORD_BITS-1:0] codeword;
   logic [SYN_W:0]       par_hits;
   logic [LEN_W-1:0]     code_len;

   // drop data bits at and above the count
   assign data_m = bits_in & ~({WORD_BITS{1'b1}} << bit_count);

   for (genvar i = 0; i < WORD_BITS; i++) begin : g_scatter
      if (is_pow2(i + 1)) begin : g_par
         assign scattered[i] = 1'b0;
      end else begin : g_dat
         assign scattered[i] = data_m[data_index(i + 1)];
      end
   end

   // parity count r is the number of k with 2^k - k - 1 below the data length
   always_comb begin
      for (int k = 0; k <= SYN_W; k++) begin
         par_hits[k] = (k < SYN_W) &&
                       (LEN_W'((1 << k) - k - 1) < LEN_W'(bit_count));
      end
      code_len = LEN_W'(bit_count) + LEN_W'($countones(par_hits));
   end

   always_comb begin
      codeword = scattered;
      for (int k = 0; k < SYN_W; k++) begin
         if (((1 << k) - 1) < WORD_BITS) begin
            codeword[((1 << k) - 1) % WORD_BITS] = ^(scattered & parity_mask(k));
         end
      end
   end

   always_comb begin
      if (code_len > LEN_W'(CODE_BITS)) begin
         result.bits_out    = '0;
         result.out_count   = '0;
         result.range_error = 1'b1;
      end else begin
         result.bits_out    = codeword;
         result.out_count   = code_len[COUNT_W-1:0];
         result.range_error = 1'b0;
      end
      result.syndrome = '0;
   end

endmodule

// ===== rtl/hsc_decoder.sv =====
`timescale 1ns / 1ps

module hsc_decoder import hsc_pkg::*; #(
   parameter int CODE_BITS = CODE_BITS_DEFAULT
) (
   input  logic [COUNT_W-1:0]   bit_count,
   input  logic [WORD_BITS-1:0] bits_in,
   output hsc_result_type       result
);

   logic [WORD_BITS-1:0] cw_m;
   logic [WORD_BITS-1:0] cw_fix;
   logic [WORD_BITS-1:0] gathered;
   logic [SYN_W-1:0]     syn;
   logic [SYN_W-1:0]     pow_hits;
   logic                 too_long;
   logic                 syn_in_range;

   assign too_long = bit_count > COUNT_W'(CODE_BITS);
   assign cw_m     = bits_in & ~({WORD_BITS{1'b1}} << bit_count);

   always_comb begin
      for (int k = 0; k < SYN_W; k++) begin
         syn[k]      = ^(cw_m & parity_mask(k));
         pow_hits[k] = COUNT_W'(1 << k) <= bit_count;
      end
   end

   assign syn_in_range = (syn != '0) && (syn <= bit_count);
   assign cw_fix = syn_in_range ? (cw_m ^ (WORD_BITS'(1) << (syn - SYN_W'(1)))) : cw_m;

   for (genvar i = 0; i < WORD_BITS; i++) begin : g_gather
      if (i < WORD_BITS - pow2_upto(WORD_BITS)) begin : g_used
         for (genvar j = 0; j < WORD_BITS; j++) begin : g_pick
            if (!is_pow2(j + 1) && data_index(j + 1) == i) begin : g_hit
               assign gathered[i] = cw_fix[j];
            end
         end
      end else begin : g_zero
         assign gathered[i] = 1'b0;
      end
   end

   always_comb begin
      if (too_long) begin
         result.bits_out    = '0;
         result.out_count   = '0;
         result.syndrome    = '0;
         result.range_error = 1'b1;
      end else begin
         result.bits_out    = gathered;
         result.out_count   = bit_count - COUNT_W'($countones(pow_hits));
         result.syndrome    = syn;
         result.range_error = (syn != '0) && !syn_in_range;
      end
   end

endmodule

// ===== rtl/hamming_sec_codec_core.sv =====
`timescale 1ns / 1ps
// channel   dir  payload                                       handshake
// req_ch    in   kind, bit_count, bits_in                      valid/ready
// rsp_ch    out  bits_out, out_count, syndrome, range_error    valid/ready
//
// One transaction per cycle sustained while rsp_ch does not stall; an accepted
// transaction passes through the input register, then encode/decode logic into the
// result register, from which rsp_ch offers it.
// Synchronous active-high reset clears both valid flags only.
// A stall on rsp_ch holds both stages; req_ch stays ready while the input
// stage is empty or the pipeline can advance.

module hamming_sec_codec_core import hsc_pkg::*; #(
   parameter int CODE_BITS = CODE_BITS_DEFAULT
) (
   input logic      clock,
   input logic      reset,
   hsc_req_if.sink  req_ch,
   hsc_rsp_if.source rsp_ch
);

   logic           s1_valid_ff, s1_valid_in;
   hsc_item_type   s1_item_ff;
   logic           out_valid_ff, out_valid_in;
   hsc_result_type out_ff;
   hsc_result_type enc_result, dec_result;
   logic           advance;

   assign advance      = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !s1_valid_ff || advance;
   assign s1_valid_in  = req_ch.ready ? req_ch.valid : s1_valid_ff;
   assign out_valid_in = advance ? s1_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready) begin
         s1_item_ff.kind      <= req_ch.kind;
         s1_item_ff.bit_count <= req_ch.bit_count;
         s1_item_ff.bits_in   <= req_ch.bits_in;
      end
      if (advance) begin
         out_ff <= (s1_item_ff.kind == KIND_DECODE) ? dec_result : enc_result;
      end
   end

   hsc_encoder #(.CODE_BITS(CODE_BITS)) u_encoder (
      .bit_count (s1_item_ff.bit_count),
      .bits_in   (s1_item_ff.bits_in),
      .result    (enc_result)
   );

   hsc_decoder #(.CODE_BITS(CODE_BITS)) u_decoder (
      .bit_count (s1_item_ff.bit_count),
      .bits_in   (s1_item_ff.bits_in),
      .result    (dec_result)
   );

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.bits_out    = out_ff.bits_out;
   assign rsp_ch.out_count   = out_ff.out_count;
   assign rsp_ch.syndrome    = out_ff.syndrome;
   assign rsp_ch.range_error = out_ff.range_error;

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff)
      else $error("input stage lost a transaction during a stall");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_ch.ready && !s1_valid_ff |=> !out_valid_ff)
      else $error("result repeated after drain");

   a_zero_above: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ff.range_error |->
         ((out_ff.bits_out >> out_ff.out_count) == '0))
      else $error("result bits set above out_count");

   a_err_empty: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.range_error && out_ff.out_count == '0 |->
         out_ff.bits_out == '0)
      else $error("error result with no length carries data");

endmodule

// ===== verif/tb_hamming_sec_codec_core.sv =====
`timescale 1ns / 1ps

module tb_hamming_sec_codec_core import hsc_pkg::*; ();

   localparam int CODE_LIMIT   = CODE_BITS_DEFAULT;
   localparam int RANDOM_JOBS  = 1300;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int SETTLE_CYCLES = 12;
   localparam int REPORT_LINES = 40;

   typedef struct {
      hsc_item_type item;
      bit           drain_first;
   } codec_job_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hsc_req_if req_if ();
   hsc_rsp_if rsp_if ();

   hamming_sec_codec_core #(.CODE_BITS(CODE_LIMIT)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   codec_job_type  pending_jobs[$];
   hsc_result_type expected_results[$];
   int             error_count = 0;
   int             cycle_count = 0;
   logic           req_fire = 1'b0;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic bit parity_slot(input int unsigned p);
      return (p != 0) && ((p & (p - 1)) == 0);
   endfunction

   function automatic logic [63:0] len_mask(input int unsigned len);
      if (len == 0) return '0;
      if (len >= 64) return '1;
      return (64'd1 << len) - 64'd1;
   endfunction

   function automatic logic [63:0] rand_word();
      return {$urandom(), $urandom()};
   endfunction

   // Expected codec result for one transaction.
   function automatic hsc_result_type hamming_result(input hsc_item_type it);
      hsc_result_type r;
      logic [63:0]    word;
      logic [63:0]    data;
      int unsigned    n, pos, d, syn, k;
      r    = '0;
      n    = it.bit_count;
      word = '0;
      data = '0;
      d    = 0;
      syn  = 0;
      if (it.kind == KIND_ENCODE) begin
         data = it.bits_in & len_mask(n);
         pos  = 1;
         while (d < n) begin
            if (pos > CODE_LIMIT || pos > 64) begin
               r.range_error = 1'b1;
               return r;
            end
            if (!parity_slot(pos)) begin
               if (data[d]) begin
                  word[pos-1] = 1'b1;
                  syn ^= pos;
               end
               d++;
            end
            pos++;
         end
         for (k = 0; k < 7; k++) begin
            if (syn[k]) word[((1 << k) - 1) & 63] = 1'b1;
         end
         r.bits_out  = word;
         r.out_count = 7'(pos - 1);
      end else begin
         if (n > CODE_LIMIT || n > 64) begin
            r.range_error = 1'b1;
            return r;
         end
         word = it.bits_in & len_mask(n);
         for (pos = 1; pos <= n; pos++) begin
            if (word[pos-1]) syn ^= pos;
         end
         if (syn != 0) begin
            if (syn <= n) word[syn-1] = ~word[syn-1];
            else r.range_error = 1'b1;
         end
         for (pos = 1; pos <= n; pos++) begin
            if (!parity_slot(pos)) begin
               data[d] = word[pos-1];
               d++;
            end
         end
         r.bits_out  = data;
         r.out_count = 7'(d);
         r.syndrome  = 7'(syn);
      end
      return r;
   endfunction

   function automatic hsc_result_type build_codeword(input int unsigned n,
                                                     input logic [63:0] data);
      hsc_item_type it;
      it.kind      = KIND_ENCODE;
      it.bit_count = 7'(n);
      it.bits_in   = data;
      return hamming_result(it);
   endfunction

   task automatic add_job(input logic kind, input int unsigned count,
                          input logic [63:0] bits, input bit drain_first = 1'b0);
      codec_job_type job;
      job.item.kind      = kind;
      job.item.bit_count = 7'(count);
      job.item.bits_in   = bits;
      job.drain_first    = drain_first;
      pending_jobs = {pending_jobs, job};
   endtask

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= REPORT_LINES)
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endtask

   // Driver: bursts of transactions separated by random gaps.
   always @(negedge clock) begin
      codec_job_type job;
      int            burst_left;
      int            gap_left;
      if (reset) begin
         req_if.valid <= 1'b0;
         burst_left = $urandom_range(1, 30);
         gap_left   = 0;
      end else if (!req_if.valid || req_fire) begin
         if (gap_left > 0) begin
            req_if.valid <= 1'b0;
            gap_left--;
         end else if (pending_jobs.size() == 0) begin
            req_if.valid <= 1'b0;
         end else if (pending_jobs[0].drain_first && expected_results.size() != 0) begin
            // hold until the pipeline has emptied
            req_if.valid <= 1'b0;
         end else begin
            job = pending_jobs.pop_front();
            req_if.kind      <= job.item.kind;
            req_if.bit_count <= job.item.bit_count;
            req_if.bits_in   <= job.item.bits_in;
            req_if.valid     <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 30);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end
      end
   end

   // Receiver: stall pattern that switches mode whenever its random phase count runs out.
   always @(negedge clock) begin
      int          stall_mode;
      int          stall_phase;
      logic [31:0] stall_pattern;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_phase = 0;
      end else begin
         if (stall_phase <= 0) begin
            stall_mode    = $urandom_range(0, 3);
            stall_phase   = $urandom_range(20, 120);
            stall_pattern = $urandom();
         end
         stall_phase--;
         case (stall_mode)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= stall_pattern[0];
            2: rsp_if.ready <= stall_pattern[0] & stall_pattern[1];
            default: rsp_if.ready <= ($urandom_range(0, 3) != 0);
         endcase
         stall_pattern = {stall_pattern[0], stall_pattern[31:1]};
      end
   end

   // Monitor: check results in order, record accepted transactions.
   always @(posedge clock) begin
      hsc_result_type want;
      hsc_item_type   taken;
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("status: fail");
         $finish;
      end
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result with nothing expected");
            end else begin
               want = expected_results.pop_front();
               if (rsp_if.bits_out !== want.bits_out)
                  report_mismatch($sformatf("bits_out %h, expected %h",
                                            rsp_if.bits_out, want.bits_out));
               if (rsp_if.out_count !== want.out_count)
                  report_mismatch($sformatf("out_count %0d, expected %0d",
                                            rsp_if.out_count, want.out_count));
               if (rsp_if.syndrome !== want.syndrome)
                  report_mismatch($sformatf("syndrome %0d, expected %0d",
                                            rsp_if.syndrome, want.syndrome));
               if (rsp_if.range_error !== want.range_error)
                  report_mismatch($sformatf("range_error %b, expected %b",
                                            rsp_if.range_error, want.range_error));
            end
         end
         req_fire <= req_if.valid && req_if.ready;
         if (req_if.valid && req_if.ready) begin
            taken.kind      = req_if.kind;
            taken.bit_count = req_if.bit_count;
            taken.bits_in   = req_if.bits_in;
            expected_results = {expected_results, hamming_result(taken)};
         end
      end
   end

   initial begin
      hsc_result_type cw;
      logic [63:0]    word;
      int unsigned    n, len, sel;
      req_if.valid     = 1'b0;
      req_if.kind      = KIND_ENCODE;
      req_if.bit_count = '0;
      req_if.bits_in   = '0;
      rsp_if.ready     = 1'b0;

      // directed corners
      add_job(KIND_ENCODE, 0, '1);
      add_job(KIND_ENCODE, 1, '1);
      add_job(KIND_ENCODE, 4, 64'hB);
      add_job(KIND_ENCODE, 3, '1);
      add_job(KIND_ENCODE, 57, '1);
      add_job(KIND_ENCODE, 57, '0);
      add_job(KIND_ENCODE, 58, '1);
      add_job(KIND_ENCODE, 64, rand_word());
      add_job(KIND_DECODE, 0, '1);
      add_job(KIND_DECODE, 1, '1);
      add_job(KIND_DECODE, 2, 64'h2);
      add_job(KIND_DECODE, 3, 64'h3);
      add_job(KIND_DECODE, 64, '1);
      add_job(KIND_DECODE, 64, '0, 1'b1);
      cw = build_codeword(57, rand_word());
      add_job(KIND_DECODE, 63, cw.bits_out);
      add_job(KIND_DECODE, 63, cw.bits_out ^ 64'h1);
      add_job(KIND_DECODE, 63, cw.bits_out ^ (64'h1 << 62));
      add_job(KIND_DECODE, 63, cw.bits_out ^ (64'h1 << 31));
      add_job(KIND_DECODE, 63, cw.bits_out ^ 64'h6);
      add_job(KIND_DECODE, 64, cw.bits_out | (64'h1 << 63));
      // positions 3 and 4 give a syndrome past the end of the word
      add_job(KIND_DECODE, 6, 64'hC);
      add_job(KIND_DECODE, 7, '1);

      for (int i = 0; i < RANDOM_JOBS; i++) begin
         sel = $urandom_range(0, 99);
         if (sel < 35) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(58, 64) : $urandom_range(0, 57);
            add_job(KIND_ENCODE, n, rand_word(), (i % 250) == 249);
         end else if (sel < 85) begin
            cw   = build_codeword($urandom_range(0, 57), rand_word());
            len  = cw.out_count;
            word = cw.bits_out;
            if (len < 64 && $urandom_range(0, 7) == 0) begin
               word[len] = 1'($urandom_range(0, 1));
               len++;
            end
            sel = $urandom_range(0, 9);
            if (len != 0 && sel < 5) begin
               word[$urandom_range(0, len - 1)] ^= 1'b1;
            end else if (len > 1 && sel == 5) begin
               word[$urandom_range(0, len - 1)] ^= 1'b1;
               word[$urandom_range(0, len - 1)] ^= 1'b1;
            end
            if ($urandom_range(0, 1) == 1) word |= rand_word() & ~len_mask(len);
            add_job(KIND_DECODE, len, word, (i % 250) == 249);
         end else begin
            add_job(KIND_DECODE, $urandom_range(0, 64), rand_word(), (i % 250) == 249);
         end
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (pending_jobs.size() != 0 || req_if.valid || expected_results.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
